>>> sv/arlt_pkg.sv
`timescale 1ns / 1ps
package arlt_pkg;

  localparam int DefaultTableDepth = 64;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // Command handed from front to back
  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] addr;
    logic [63:0] region_length;
    logic [63:0] file_offset;
    logic [15:0] lib_number;
  } cmd_t;

  // Stored region, one memory word
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] length;
    logic [63:0] file_offset;
    logic [15:0] lib;
  } slot_t;

  typedef struct packed {
    logic [15:0] found_lib;
    logic [63:0] result_offset;
    logic [1:0]  status;
  } rsp_t;

endpackage

>>> sv/arlt_ram.sv
`timescale 1ns / 1ps
module arlt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/arlt_fifo.sv
`timescale 1ns / 1ps
module arlt_fifo #(
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [Width-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [Width-1:0] rdata
);

  // Two-entry queue
  logic [Width-1:0] mem_r [2];
  logic             wptr_r, rptr_r;
  logic [1:0]       cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) wptr_r <= !wptr_r;
      if (do_pop)  rptr_r <= !rptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

`ifndef SYNTH
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
`endif

endmodule

>>> sv/arlt_back.sv
`timescale 1ns / 1ps
module arlt_back #(
  parameter int TableDepth = arlt_pkg::DefaultTableDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  arlt_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           rsp_valid,
  output arlt_pkg::rsp_t rsp,
  input  logic           rsp_ready
);
  import arlt_pkg::*;

  localparam int AW = $clog2(TableDepth);
  localparam int CW = $clog2(TableDepth + 1);
  localparam int SW = $bits(slot_t);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_HIT  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] used_r;
  logic [CW-1:0] idx_r;
  logic          rd_pend_r;
  cmd_t          cur_r;
  logic          have_r;
  slot_t         best_r;
  logic          dup_r;
  rsp_t          rsp_r;

  logic          we;
  logic [AW-1:0] raddr;
  logic [SW-1:0] rdata_raw;
  slot_t         rd;
  logic [63:0]   diff;

  assign rd = slot_t'(rdata_raw);

  arlt_ram #(.Width(SW), .Depth(TableDepth)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (used_r[AW-1:0]),
    .wdata ({cur_r.addr, cur_r.region_length, cur_r.file_offset, cur_r.lib_number}),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign raddr     = idx_r[AW-1:0];
  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid;
  assign rsp_valid = (state_r == S_OUT);
  assign rsp       = rsp_r;
  assign we = (state_r == S_FIN) && (cur_r.func == OP_INSERT) && !dup_r
              && (used_r != CW'(TableDepth));
  assign diff = cur_r.addr - best_r.base;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (cmd_valid) state_nxt = S_SCAN;
      S_SCAN: if (idx_r >= used_r && !rd_pend_r) state_nxt = S_FIN;
      S_FIN:  state_nxt = (cur_r.func == OP_LOOKUP) ? S_HIT : S_OUT;
      S_HIT:  state_nxt = S_OUT;
      S_OUT:  if (rsp_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      used_r    <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Track the pending registered read of the region memory
      rd_pend_r <= (state_r == S_SCAN) && (idx_r < used_r);
      if (state_r == S_IDLE && cmd_valid && cmd.func == OP_CLEAR) used_r <= '0;
      if (we) used_r <= used_r + 1'b1;
    end
  end

  // Scan datapath: one slot per cycle
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      cur_r  <= cmd;
      idx_r  <= '0;
      have_r <= 1'b0;
      dup_r  <= 1'b0;
    end else if (state_r == S_SCAN) begin
      if (idx_r < used_r) idx_r <= idx_r + 1'b1;
      if (rd_pend_r) begin
        if (rd.base == cur_r.addr) dup_r <= 1'b1;
        if (rd.base <= cur_r.addr && (!have_r || rd.base > best_r.base)) begin
          have_r <= 1'b1;
          best_r <= rd;
        end
      end
    end
    // Form the result
    if (state_r == S_FIN) begin
      rsp_r.found_lib     <= '0;
      rsp_r.result_offset <= '0;
      if (cur_r.func == OP_INSERT && dup_r) begin
        rsp_r.status <= ST_DUP;
      end else if (cur_r.func == OP_INSERT && used_r == CW'(TableDepth)) begin
        rsp_r.status <= ST_FULL;
      end else begin
        rsp_r.status <= ST_OK;
      end
    end else if (state_r == S_HIT) begin
      if (have_r && diff < best_r.length) begin
        rsp_r.found_lib     <= best_r.lib;
        rsp_r.result_offset <= diff + best_r.file_offset;
        rsp_r.status        <= ST_OK;
      end else begin
        rsp_r.found_lib     <= '0;
        rsp_r.result_offset <= cur_r.addr;
        rsp_r.status        <= ST_MISS;
      end
    end
  end

`ifndef SYNTH
  a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(TableDepth)) else $error("fill count overflow");
  a_we_scan: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> !rd_pend_r) else $error("write during scan");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> state_r == S_SCAN) else $error("pop without scan");
`endif

endmodule

>>> sv/address_range_translate_table_unit.sv
`timescale 1ns / 1ps
// Address region table: clear, insert and lookup of up to TABLE_DEPTH
// regions. Items enter a two-entry queue, a sequencer then scans the
// occupied slots of the region memory at one slot per cycle, and results
// leave through another two-entry queue. The sequencer takes the next item
// only after the result of the last has been taken by the output queue.
// The region memory has a single read port, and its read is registered.
// No clearing pass.
module address_range_translate_table_unit #(
  parameter int TABLE_DEPTH = arlt_pkg::DefaultTableDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_addr,
  input  logic [63:0] in_region_length,
  input  logic [63:0] in_file_offset,
  input  logic [15:0] in_lib_number,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_found_lib,
  output logic [63:0] out_result_offset,
  output logic [1:0]  out_status
);
  import arlt_pkg::*;

  cmd_t in_cmd, q_cmd;
  rsp_t b_rsp, o_rsp;
  logic q_empty, q_pop, b_valid, o_full;

  assign in_cmd = '{func: in_func, addr: in_addr, region_length: in_region_length,
                    file_offset: in_file_offset, lib_number: in_lib_number};

  arlt_fifo #(.Width($bits(cmd_t))) u_in_q (
    .clk(clk), .rst_n(rst_n), .push(in_push), .wdata(in_cmd), .full(in_full),
    .pop(q_pop), .empty(q_empty), .rdata(q_cmd)
  );

  arlt_back #(.TableDepth(TABLE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(!q_empty), .cmd(q_cmd), .cmd_pop(q_pop),
    .rsp_valid(b_valid), .rsp(b_rsp), .rsp_ready(!o_full)
  );

  arlt_fifo #(.Width($bits(rsp_t))) u_out_q (
    .clk(clk), .rst_n(rst_n), .push(b_valid), .wdata(b_rsp), .full(o_full),
    .pop(out_pop), .empty(out_empty), .rdata(o_rsp)
  );

  assign out_found_lib     = o_rsp.found_lib;
  assign out_result_offset = o_rsp.result_offset;
  assign out_status        = o_rsp.status;

endmodule
